// File: rtl/top_k_score_selector_core_defines.svh
// ----------------------------------------------------------------------------
// Top-k score selector: assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef TOP_K_SCORE_SELECTOR_CORE_DEFINES_SVH
`define TOP_K_SCORE_SELECTOR_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TKS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TKS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/tks_pkg.sv
// ----------------------------------------------------------------------------
// Top-k score selector package
// Sizes, word types and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package tks_pkg;

	localparam int MAX_K    = 32;
	localparam int POS_BITS = 20;
	localparam int IDX_W    = $clog2(MAX_K);
	localparam int CNT_W    = $clog2(MAX_K + 1);
	localparam int TOP_W    = 6;
	localparam int SCORE_W  = 32;
	localparam int RANK_W   = 5;

	typedef struct packed {
		logic signed [SCORE_W-1:0] score;
		logic                      last_item;
	} in_word_t;

	typedef struct packed {
		logic [RANK_W-1:0]         rank;
		logic [POS_BITS-1:0]       doc_number;
		logic signed [SCORE_W-1:0] doc_score;
		logic                      last_result;
	} out_word_t;

	typedef struct packed {
		logic insert;
		logic drain_step;
	} tks_cmd_t;

	typedef struct packed {
		logic count_zero;
		logic count_one;
	} tks_status_t;

endpackage

// File: rtl/tks_controller.sv
// ----------------------------------------------------------------------------
// Top-k score selector controller
// Accepts words while idle and steps the datapath through the ranked drain.
// ----------------------------------------------------------------------------
module tks_controller import tks_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        last_item,
	input  tks_status_t status,
	output tks_cmd_t    cmd,
	output logic        busy
);

	typedef enum logic {
		ST_IDLE,
		ST_DRAIN
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start && last_item) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (status.count_zero || status.count_one) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		busy           = (state_q == ST_DRAIN);
		cmd.insert     = (state_q == ST_IDLE) && start;
		cmd.drain_step = (state_q == ST_DRAIN) && !status.count_zero;
	end

endmodule

// File: rtl/tks_datapath.sv
// ----------------------------------------------------------------------------
// Top-k score selector datapath
// Sorted entry row with parallel compare-and-shift insertion and shift-out.
// ----------------------------------------------------------------------------
module tks_datapath import tks_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [TOP_W-1:0] cfg_wdata,
	input  in_word_t         item,
	input  tks_cmd_t         cmd,
	output tks_status_t      status,
	output logic             strobe,
	output out_word_t        result
);

	logic [TOP_W-1:0]          top_count_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [POS_BITS-1:0]       pos_q;
	logic [RANK_W-1:0]         rank_q;
	logic signed [SCORE_W-1:0] score_q  [MAX_K];
	logic [POS_BITS-1:0]       number_q [MAX_K];
	logic                      strobe_q;
	out_word_t                 result_q;

	logic [CNT_W-1:0]          k_eff;
	logic [CNT_W-1:0]          cnt_c;
	logic [CNT_W-1:0]          cnt_ins;
	logic [MAX_K-1:0]          go;
	logic [MAX_K-1:0]          in_k;
	logic                      ins;
	logic signed [SCORE_W-1:0] score_n  [MAX_K];
	logic [POS_BITS-1:0]       number_n [MAX_K];

	always_comb begin
		if (top_count_q > TOP_W'(MAX_K)) begin
			k_eff = CNT_W'(MAX_K);
		end else begin
			k_eff = CNT_W'(top_count_q);
		end
		cnt_c = (cnt_q > k_eff) ? k_eff : cnt_q;
		for (int i = 0; i < MAX_K; i++) begin
			go[i] = (CNT_W'(i) >= cnt_c) || (item.score > score_q[i]) ||
				((item.score == score_q[i]) && (pos_q < number_q[i]));
			in_k[i] = CNT_W'(i) < k_eff;
		end
		ins = |(go & in_k);
		if (ins && (cnt_c < k_eff)) begin
			cnt_ins = cnt_c + CNT_W'(1);
		end else begin
			cnt_ins = cnt_c;
		end
		for (int i = 0; i < MAX_K; i++) begin
			score_n[i]  = score_q[i];
			number_n[i] = number_q[i];
			if (in_k[i] && go[i]) begin
				if (i == 0 || !go[(i == 0) ? 0 : i - 1]) begin
					score_n[i]  = item.score;
					number_n[i] = pos_q;
				end else begin
					score_n[i]  = score_q[(i == 0) ? 0 : i - 1];
					number_n[i] = number_q[(i == 0) ? 0 : i - 1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_count_q <= TOP_W'(10);
			cnt_q       <= '0;
			pos_q       <= '0;
			rank_q      <= '0;
			strobe_q    <= 1'b0;
		end else begin
			strobe_q <= cmd.drain_step;
			if (cfg_we) begin
				top_count_q <= cfg_wdata;
			end
			if (cmd.insert) begin
				cnt_q  <= cnt_ins;
				rank_q <= '0;
				if (item.last_item) begin
					pos_q <= '0;
				end else if (pos_q != {POS_BITS{1'b1}}) begin
					pos_q <= pos_q + POS_BITS'(1);
				end
			end else if (cmd.drain_step) begin
				cnt_q  <= cnt_q - CNT_W'(1);
				rank_q <= rank_q + RANK_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.insert) begin
			for (int i = 0; i < MAX_K; i++) begin
				score_q[i]  <= score_n[i];
				number_q[i] <= number_n[i];
			end
		end else if (cmd.drain_step) begin
			for (int i = 0; i < MAX_K - 1; i++) begin
				score_q[i]  <= score_q[i+1];
				number_q[i] <= number_q[i+1];
			end
			result_q.rank        <= rank_q;
			result_q.doc_number  <= number_q[0];
			result_q.doc_score   <= score_q[0];
			result_q.last_result <= (cnt_q == CNT_W'(1));
		end
	end

	always_comb begin
		status.count_zero = (cnt_q == '0);
		status.count_one  = (cnt_q == CNT_W'(1));
		strobe            = strobe_q;
		result            = result_q;
	end

endmodule

// File: rtl/top_k_score_selector_core.sv
// ----------------------------------------------------------------------------
// Top-k score selector core
// Keeps the best scores of a query in rank order and reports them at its end.
//
// Channel   Handshake              Word
// input     start, busy            item   (score, last_item)
// result    strobe                 result (rank, doc_number, doc_score, last_result)
// config    cfg_we                 cfg_wdata (top_count)
//
// A word is taken while busy is low; insertion compares it against all kept
// entries at once. After the last word the block is busy while it reports the
// kept entries, one per drain step, and also when there is none to report. Each
// result appears in the cycle after its drain step; the receiver cannot stall
// it. Reset clears the count, rank, position and state; top_count resets to 10.
// ----------------------------------------------------------------------------
`include "top_k_score_selector_core_defines.svh"

module top_k_score_selector_core import tks_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  in_word_t         item,
	output logic             busy,
	input  logic             cfg_we,
	input  logic [TOP_W-1:0] cfg_wdata,
	output logic             strobe,
	output out_word_t        result
);

	tks_cmd_t    cmd;
	tks_status_t status;

	tks_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.last_item (item.last_item),
		.status    (status),
		.cmd       (cmd),
		.busy      (busy)
	);

	tks_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.item      (item),
		.cmd       (cmd),
		.status    (status),
		.strobe    (strobe),
		.result    (result)
	);

	`TKS_ASSERT_NEXT(a_step_gives_result, cmd.drain_step, strobe, "drain step lost its result")
	`TKS_ASSERT_NEXT(a_last_sets_busy, start && !busy && item.last_item, busy,
		"last word did not start the drain")
	`TKS_ASSERT_NOW(a_final_frees, strobe && result.last_result, !busy,
		"still busy after the final result")
	`TKS_ASSERT_NOW(a_no_step_idle, !busy, !cmd.drain_step, "drain step while idle")

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Top-k score selector testbench
// Directed queries from a stimulus table, then random queries. Every accepted
// word runs through a ranking model in the bench, and each result word is
// compared with the oldest predicted ranking entry.
// ----------------------------------------------------------------------------
module tb;
	import tks_pkg::*;

	localparam int CLK_HALF = 2;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int RANDOM_WORDS = 150;
	localparam int CFG_SETTLE = 4;
	localparam logic [POS_BITS-1:0] DOC_MAX = '1;

	typedef struct {
		int                        top_count;
		logic signed [SCORE_W-1:0] score;
		bit                        last_item;
		bit                        typed;
		bit                        typed_hit;
		logic [POS_BITS-1:0]       typed_doc;
	} stim_row_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	in_word_t         item = '0;
	logic             busy;
	logic             cfg_we = 1'b0;
	logic [TOP_W-1:0] cfg_wdata = '0;
	logic             strobe;
	out_word_t        result;

	top_k_score_selector_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item),
		.busy      (busy),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.strobe    (strobe),
		.result    (result)
	);

	always #CLK_HALF clk = ~clk;

	// Ranking model state.
	int                        keep_limit = 10;
	logic signed [SCORE_W-1:0] held_score [MAX_K];
	logic [POS_BITS-1:0]       held_doc [MAX_K];
	int                        held_n = 0;
	logic [POS_BITS-1:0]       next_doc = '0;

	out_word_t   ranking_q [$];
	stim_row_t   stim_table [$];
	int          mismatches = 0;
	int unsigned cycle_count = 0;

	function automatic bit outranks(input logic signed [SCORE_W-1:0] sa,
			input logic [POS_BITS-1:0] na, input logic signed [SCORE_W-1:0] sb,
			input logic [POS_BITS-1:0] nb);
		if (sa != sb)
			return sa > sb;
		return na < nb;
	endfunction

	function automatic void rank_score(input in_word_t w, input bit emit);
		int k;
		int p;
		int i;
		int top;
		out_word_t r;
		k = (keep_limit < MAX_K) ? keep_limit : MAX_K;
		if (held_n > k)
			held_n = k;
		p = 0;
		while (p < held_n && !outranks(w.score, next_doc, held_score[p], held_doc[p]))
			p++;
		if (p < k) begin
			top = (held_n < k) ? held_n : k - 1;
			for (i = top; i > p; i--) begin
				held_score[i] = held_score[i-1];
				held_doc[i] = held_doc[i-1];
			end
			held_score[p] = w.score;
			held_doc[p] = next_doc;
			if (held_n < k)
				held_n++;
		end
		if (next_doc != DOC_MAX)
			next_doc++;
		if (w.last_item) begin
			if (emit) begin
				for (i = 0; i < held_n; i++) begin
					r.rank = i[RANK_W-1:0];
					r.doc_number = held_doc[i];
					r.doc_score = held_score[i];
					r.last_result = (i == held_n - 1);
					ranking_q = {ranking_q, r};
				end
			end
			held_n = 0;
			next_doc = '0;
		end
	endfunction

	function automatic void report(input string field, input longint want,
			input longint got);
		mismatches++;
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
	endfunction

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && strobe) begin
			if (ranking_q.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result word, actual rank %0d doc %0d score %0d",
					$time, result.rank, result.doc_number, result.doc_score);
			end else begin
				want = ranking_q.pop_front();
				if (result.rank !== want.rank)
					report("rank", want.rank, result.rank);
				if (result.doc_number !== want.doc_number)
					report("doc_number", want.doc_number, result.doc_number);
				if (result.doc_score !== want.doc_score)
					report("doc_score", want.doc_score, result.doc_score);
				if (result.last_result !== want.last_result)
					report("last_result", want.last_result, result.last_result);
			end
		end
	end

	task automatic send_word(input in_word_t w, input bit emit);
		@(negedge clk);
		start = 1'b1;
		item = w;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		rank_score(w, emit);
	endtask

	task automatic hold_off(input int cycles);
		if (cycles > 0) begin
			@(negedge clk);
			start = 1'b0;
			repeat (cycles - 1) @(negedge clk);
		end
	endtask

	task automatic drain_ranking();
		@(negedge clk);
		start = 1'b0;
		while (ranking_q.size() != 0)
			@(posedge clk);
		hold_off(CFG_SETTLE);
	endtask

	task automatic set_top_count(input int value);
		drain_ranking();
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = value[TOP_W-1:0];
		@(negedge clk);
		cfg_we = 1'b0;
		keep_limit = value;
	endtask

	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	function automatic logic signed [SCORE_W-1:0] pick_score();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom;
			4, 5: return $signed($urandom_range(0, 15)) - 8;
			6: return 32'sh7fff_ffff;
			7: return 32'sh8000_0000;
			8: return '0;
			default: return $signed($urandom_range(0, 3)) <<< 16;
		endcase
	endfunction

	function automatic int pick_top_count();
		case ($urandom_range(0, 11))
			0: return 0;
			1: return 1;
			2: return MAX_K;
			3: return (1 << TOP_W) - 1;
			4: return MAX_K + 1;
			default: return $urandom_range(2, 12);
		endcase
	endfunction

	function automatic void add_row(input int tc, input logic signed [SCORE_W-1:0] s,
			input bit lst, input bit typed, input bit hit, input int doc);
		stim_row_t row;
		row.top_count = tc;
		row.score = s;
		row.last_item = lst;
		row.typed = typed;
		row.typed_hit = hit;
		row.typed_doc = doc[POS_BITS-1:0];
		stim_table = {stim_table, row};
	endfunction

	initial begin
		in_word_t w;
		out_word_t r;
		int sent;
		int qlen;
		bit burst;

		// top_count of -1 leaves the register alone for that row.
		add_row(-1, 32'sh7fff_ffff, 1, 1, 1, 0);
		add_row(-1, 32'sh8000_0000, 1, 1, 1, 0);
		add_row(0, 5, 1, 1, 0, 0);
		add_row(1, 7, 0, 0, 0, 0);
		add_row(-1, 9, 0, 0, 0, 0);
		add_row(-1, 9, 1, 1, 1, 1);
		add_row(MAX_K, 32'sh8000_0000, 0, 0, 0, 0);
		add_row(-1, 32'sh7fff_ffff, 0, 0, 0, 0);
		add_row(-1, 0, 0, 0, 0, 0);
		add_row(-1, 0, 0, 0, 0, 0);
		add_row(-1, -1, 0, 0, 0, 0);
		add_row(-1, 32'sh8000_0000, 1, 0, 0, 0);
		add_row((1 << TOP_W) - 1, 3, 0, 0, 0, 0);
		add_row(-1, 3, 1, 0, 0, 0);
		add_row(10, 1, 0, 0, 0, 0);
		add_row(-1, 2, 0, 0, 0, 0);
		add_row(-1, 3, 0, 0, 0, 0);
		add_row(-1, 4, 0, 0, 0, 0);
		add_row(-1, 5, 0, 0, 0, 0);
		add_row(2, 0, 0, 0, 0, 0);
		add_row(-1, 10, 1, 0, 0, 0);
		add_row(MAX_K + 1, -5, 1, 1, 1, 0);

		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		foreach (stim_table[n]) begin
			if (stim_table[n].top_count >= 0)
				set_top_count(stim_table[n].top_count);
			w.score = stim_table[n].score;
			w.last_item = stim_table[n].last_item;
			send_word(w, !stim_table[n].typed);
			if (stim_table[n].typed && stim_table[n].typed_hit) begin
				r.rank = '0;
				r.doc_number = stim_table[n].typed_doc;
				r.doc_score = stim_table[n].score;
				r.last_result = 1'b1;
				ranking_q = {ranking_q, r};
			end
		end

		sent = 0;
		while (sent < RANDOM_WORDS) begin
			if ($urandom_range(0, 3) == 0)
				set_top_count(pick_top_count());
			qlen = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 12);
			burst = ($urandom_range(0, 3) == 0);
			for (int j = 0; j < qlen; j++) begin
				w.score = pick_score();
				w.last_item = (j == qlen - 1);
				send_word(w, 1'b1);
				sent++;
				if (!w.last_item && $urandom_range(0, 15) == 0)
					set_top_count(pick_top_count());
				else if (!burst)
					hold_off(idle_gap());
			end
			if ($urandom_range(0, 5) == 0)
				drain_ranking();
		end

		@(negedge clk);
		start = 1'b0;
		while (ranking_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
